/* rtl/core/tvp_pkg.sv */
// package: types, constants and helpers shared by the vertex projector
package tvp_pkg;

  localparam int TRIG_TABLE_BITS = 10;
  localparam int CORDIC_STEPS    = 14;
  localparam int STEP_W          = 4;

  localparam int REG_SPIN_SPEED    = 0;
  localparam int REG_SHAPE_SCALE   = 1;
  localparam int REG_CANVAS_CENTER = 2;
  localparam int REG_SPIN_ENABLED  = 3;

  localparam logic [11:0] SPIN_SPEED_RST    = 12'd209;
  localparam logic [15:0] SHAPE_SCALE_RST   = 16'd4139;
  localparam logic [9:0]  CANVAS_CENTER_RST = 10'd32;

  localparam logic signed [15:0] ONE_Q14      = 16'sd16384;
  localparam logic signed [15:0] TILT_COS_RST = 16'sd13968;
  localparam logic signed [15:0] TILT_SIN_RST = 16'sd8564;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008219;
  localparam logic signed [16:0] TILT_BASE   = 17'sd5737;
  localparam logic signed [15:0] TILT_SWING  = 16'sd3129;
  localparam logic [15:0]        TILT_RATE   = 16'd41288;
  localparam logic signed [17:0] DIST_Q13    = 18'sd24576;

  localparam int DIV_NUM_W = 40;
  localparam int DIV_DEN_W = 23;

  function automatic logic [13:0] atan_unit(input logic [STEP_W-1:0] i);
    logic [13:0] v;
    case (i)
      4'd0:  v = 14'd8192;
      4'd1:  v = 14'd4836;
      4'd2:  v = 14'd2555;
      4'd3:  v = 14'd1297;
      4'd4:  v = 14'd651;
      4'd5:  v = 14'd326;
      4'd6:  v = 14'd163;
      4'd7:  v = 14'd81;
      4'd8:  v = 14'd41;
      4'd9:  v = 14'd20;
      4'd10: v = 14'd10;
      4'd11: v = 14'd5;
      4'd12: v = 14'd3;
      4'd13: v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

  typedef enum logic [4:0] {
    MUL_SRC_NONE = 5'b00001,
    MUL_SRC_ROT  = 5'b00010,
    MUL_SRC_TILT = 5'b00100,
    MUL_SRC_NUMX = 5'b01000,
    MUL_SRC_NUMY = 5'b10000
  } mul_src_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load_vert;
    logic       tick_advance;
    logic       cordic_start;
    logic [1:0] cordic_sel;    // 0 spin, 1 tilt phase, 2 tilt angle
    logic       cordic_store;
    logic       rot_x1z1;
    logic       rot_y2z2;
    logic       div_start;
    logic       div_sel_y;
    logic       div_store;
    logic       out_load;
  } tvp_cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic div_done;
  } tvp_sts_t;

endpackage

/* rtl/core/tvp_cordic.sv */
// iterative cordic: one rotation step per cycle, cosine and sine in q1.14
module tvp_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [15:0]         angle,
  output logic                done,
  output logic signed [15:0]  cos_q14,
  output logic signed [15:0]  sin_q14
);

  localparam int DROP = 16 - tvp_pkg::TRIG_TABLE_BITS;

  logic signed [31:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [16:0] z_r, z_nxt;
  logic [tvp_pkg::STEP_W-1:0] i_r, i_nxt;
  logic busy_r, busy_nxt, flip_r, flip_nxt, done_r, done_nxt;

  logic [16:0] q_full;
  logic [15:0] q_a;
  logic signed [16:0] a0, a1;
  logic fl;
  logic signed [31:0] xs, ys;
  logic signed [32:0] xr, yr;
  logic signed [18:0] xq, yq;

  always_comb begin
    q_full = ({1'b0, angle} + 17'(1 << (DROP - 1))) >> DROP << DROP;
    q_a = q_full[15:0];
    a0 = {q_a[15], q_a};
    a1 = a0;
    fl = 1'b0;
    if (a0 > 17'sd16384) begin
      a1 = a0 - 17'sd32768;
      fl = 1'b1;
    end else if (a0 < -17'sd16384) begin
      a1 = a0 + 17'sd32768;
      fl = 1'b1;
    end
  end

  always_comb begin
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    i_nxt = i_r;
    busy_nxt = busy_r;
    flip_nxt = flip_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt = tvp_pkg::CORDIC_GAIN;
      y_nxt = '0;
      z_nxt = a1;
      i_nxt = '0;
      flip_nxt = fl;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[16]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - 17'(tvp_pkg::atan_unit(i_r));
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + 17'(tvp_pkg::atan_unit(i_r));
      end
      i_nxt = i_r + tvp_pkg::STEP_W'(1);
      if (i_r == tvp_pkg::STEP_W'(tvp_pkg::CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
    flip_r <= flip_nxt;
  end

  always_comb begin
    xr = ({x_r[31], x_r} + 33'sd8192) >>> 14;
    yr = ({y_r[31], y_r} + 33'sd8192) >>> 14;
    xq = flip_r ? -xr[18:0] : xr[18:0];
    yq = flip_r ? -yr[18:0] : yr[18:0];
    if (xq > 19'sd16384) cos_q14 = 16'sd16384;
    else if (xq < -19'sd16384) cos_q14 = -16'sd16384;
    else cos_q14 = xq[15:0];
    if (yq > 19'sd16384) sin_q14 = 16'sd16384;
    else if (yq < -19'sd16384) sin_q14 = -16'sd16384;
    else sin_q14 = yq[15:0];
  end

  assign done = done_r;

endmodule

/* rtl/core/tvp_divider.sv */
// restoring divider, one quotient bit per cycle
module tvp_divider (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [tvp_pkg::DIV_NUM_W-1:0]     num,
  input  logic [tvp_pkg::DIV_DEN_W-1:0]     den,
  output logic                              done,
  output logic [tvp_pkg::DIV_NUM_W-1:0]     quot
);

  localparam int NW = tvp_pkg::DIV_NUM_W;
  localparam int DW = tvp_pkg::DIV_DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [DW:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

/* rtl/core/tvp_datapath.sv */
// datapath: angle state, trig registers, rotation, projection and output
module tvp_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tvp_pkg::tvp_cmd_t    cmd,
  output tvp_pkg::tvp_sts_t    sts,
  input  logic [47:0]          vert_in,
  input  logic [11:0]          spin_speed,
  input  logic [15:0]          shape_scale,
  input  logic [9:0]           canvas_center,
  output logic [31:0]          out_data
);

  logic [15:0] spin_angle_r, spin_angle_nxt, tilt_phase_r, tilt_phase_nxt;
  logic signed [15:0] spin_cos_r, spin_sin_r, tilt_cos_r, tilt_sin_r;
  logic signed [15:0] vx_r, vy_r, vz_r;
  logic signed [17:0] x1_r, z1_r, y2_r, z2_r;
  logic [15:0] tilt_u_r;
  logic [31:0] out_r;

  logic [15:0] cord_angle;
  logic cord_done;
  logic signed [15:0] cord_cos, cord_sin;

  logic [27:0] tstep_full;
  logic [11:0] tstep;

  always_comb begin
    tstep_full = 28'(spin_speed) * 28'(tvp_pkg::TILT_RATE) + 28'd32768;
    tstep = tstep_full[27:16];
    spin_angle_nxt = spin_angle_r + 16'(spin_speed);
    tilt_phase_nxt = tilt_phase_r + 16'(tstep);
  end

  always_comb begin
    case (cmd.cordic_sel)
      2'd0: cord_angle = spin_angle_r;
      2'd1: cord_angle = tilt_phase_r;
      default: cord_angle = tilt_u_r;
    endcase
  end

  tvp_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cmd.cordic_start), .angle(cord_angle),
    .done(cord_done), .cos_q14(cord_cos), .sin_q14(cord_sin)
  );

  // tilt angle in binary units from the tilt phase sine
  logic signed [31:0] swing_p;
  logic signed [16:0] tilt_u_full;
  always_comb begin
    swing_p = 32'(tvp_pkg::TILT_SWING) * 32'(cord_sin) + 32'sd8192;
    tilt_u_full = tvp_pkg::TILT_BASE + 17'(swing_p >>> 14);
  end

  // rotations, two products summed per output
  logic signed [35:0] p_a, p_b, p_c, p_d;
  always_comb begin
    p_a = 36'(cmd.rot_y2z2 ? 18'(vy_r) : 18'(vx_r)) *
          36'(cmd.rot_y2z2 ? tilt_cos_r : spin_cos_r);
    p_b = 36'(cmd.rot_y2z2 ? z1_r : 18'(vz_r)) *
          36'(cmd.rot_y2z2 ? tilt_sin_r : spin_sin_r);
    p_c = 36'(cmd.rot_y2z2 ? 18'(vy_r) : 18'(vz_r)) *
          36'(cmd.rot_y2z2 ? tilt_sin_r : spin_cos_r);
    p_d = 36'(cmd.rot_y2z2 ? z1_r : 18'(vx_r)) *
          36'(cmd.rot_y2z2 ? tilt_cos_r : spin_sin_r);
  end
  logic signed [36:0] s_first, s_second;
  always_comb begin
    if (cmd.rot_y2z2) begin
      s_first  = 37'(p_a) - 37'(p_b) + 37'sd8192;
      s_second = 37'(p_c) + 37'(p_d) + 37'sd8192;
    end else begin
      s_first  = 37'(p_a) + 37'(p_b) + 37'sd8192;
      s_second = 37'(p_c) - 37'(p_d) + 37'sd8192;
    end
  end

  // projection: numerator magnitude and divisor
  logic signed [18:0] dd;
  logic [21:0] dpos;
  logic [tvp_pkg::DIV_DEN_W-1:0] den;
  logic signed [17:0] coord;
  logic [17:0] cmag;
  logic [35:0] nprod;
  logic [tvp_pkg::DIV_NUM_W-1:0] nmag, num;
  always_comb begin
    dd = 19'(z2_r) + 19'(tvp_pkg::DIST_Q13);
    dpos = (dd <= 19'sd0) ? 22'd1 : 22'(dd[17:0]);
    den = tvp_pkg::DIV_DEN_W'({dpos[17:0], 4'b0000});
    coord = cmd.div_sel_y ? y2_r : x1_r;
    cmag = coord[17] ? 18'(-coord) : 18'(coord);
    nprod = 36'(cmag) * 36'(shape_scale);
    nmag = tvp_pkg::DIV_NUM_W'(nprod) * 40'd3;
    num = nmag + tvp_pkg::DIV_NUM_W'(den >> 1);
  end

  logic div_done;
  logic [tvp_pkg::DIV_NUM_W-1:0] quot;
  tvp_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(num), .den(den),
    .done(div_done), .quot(quot)
  );

  logic signed [41:0] res;
  logic signed [15:0] sat;
  always_comb begin
    res = 42'(signed'({1'b0, canvas_center, 4'b0000})) +
          (coord[17] ? -42'(signed'({1'b0, quot})) : 42'(signed'({1'b0, quot})));
    if (res > 42'sd32767) sat = 16'sh7fff;
    else if (res < -42'sd32768) sat = -16'sd32768;
    else sat = res[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spin_angle_r <= '0;
      tilt_phase_r <= '0;
      spin_cos_r <= tvp_pkg::ONE_Q14;
      spin_sin_r <= '0;
      tilt_cos_r <= tvp_pkg::TILT_COS_RST;
      tilt_sin_r <= tvp_pkg::TILT_SIN_RST;
    end else begin
      if (cmd.tick_advance) begin
        spin_angle_r <= spin_angle_nxt;
        tilt_phase_r <= tilt_phase_nxt;
      end
      if (cmd.cordic_store) begin
        case (cmd.cordic_sel)
          2'd0: begin
            spin_cos_r <= cord_cos;
            spin_sin_r <= cord_sin;
          end
          2'd1: tilt_u_r <= tilt_u_full[15:0];
          default: begin
            tilt_cos_r <= cord_cos;
            tilt_sin_r <= cord_sin;
          end
        endcase
      end
    end
    if (cmd.load_vert) begin
      vx_r <= vert_in[15:0];
      vy_r <= vert_in[31:16];
      vz_r <= vert_in[47:32];
    end
    if (cmd.rot_x1z1) begin
      x1_r <= 18'(s_first >>> 14);
      z1_r <= 18'(s_second >>> 14);
    end
    if (cmd.rot_y2z2) begin
      y2_r <= 18'(s_first >>> 14);
      z2_r <= 18'(s_second >>> 14);
    end
    if (cmd.div_store) begin
      if (cmd.div_sel_y) out_r[31:16] <= sat;
      else out_r[15:0] <= sat;
    end
  end

  assign sts.cordic_done = cord_done;
  assign sts.div_done = div_done;
  assign out_data = out_r;

endmodule

/* rtl/core/tvp_ctrl.sv */
// controller state machine sequencing tick and vertex work
module tvp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               in_kind,
  input  logic               spin_enabled,
  input  logic               out_busy,
  input  tvp_pkg::tvp_sts_t  sts,
  output tvp_pkg::tvp_cmd_t  cmd,
  output logic               in_ready,
  output logic               out_push
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_TRIG  = 8'b00000010,
    ST_ROT1  = 8'b00000100,
    ST_ROT2  = 8'b00001000,
    ST_DIVX  = 8'b00010000,
    ST_DIVY  = 8'b00100000,
    ST_PUSH  = 8'b01000000,
    ST_START = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic first_r, first_nxt;

  always_comb begin
    state_nxt = state_r;
    sel_nxt = sel_r;
    first_nxt = 1'b0;
    cmd = '0;
    cmd.cordic_sel = sel_r;
    cmd.div_sel_y = (state_r == ST_DIVY);
    out_push = 1'b0;
    in_ready = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_kind) begin
            cmd.load_vert = 1'b1;
            state_nxt = ST_ROT1;
          end else if (spin_enabled) begin
            cmd.tick_advance = 1'b1;
            sel_nxt = 2'd0;
            state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        cmd.cordic_start = 1'b1;
        state_nxt = ST_TRIG;
      end
      ST_TRIG: begin
        if (sts.cordic_done) begin
          cmd.cordic_store = 1'b1;
          if (sel_r == 2'd2) state_nxt = ST_IDLE;
          else begin
            sel_nxt = sel_r + 2'd1;
            state_nxt = ST_START;
          end
        end
      end
      ST_ROT1: begin
        cmd.rot_x1z1 = 1'b1;
        state_nxt = ST_ROT2;
      end
      ST_ROT2: begin
        cmd.rot_y2z2 = 1'b1;
        first_nxt = 1'b1;
        state_nxt = ST_DIVX;
      end
      ST_DIVX: begin
        if (first_r) cmd.div_start = 1'b1;
        else if (sts.div_done) begin
          cmd.div_store = 1'b1;
          first_nxt = 1'b1;
          state_nxt = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (first_r) cmd.div_start = 1'b1;
        else if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_busy) begin
          out_push = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      first_r <= 1'b0;
      sel_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      sel_r <= sel_nxt;
    end
  end

endmodule

/* rtl/core/tumbling_vertex_projector.sv */
// top level: tumbling vertex projector with stream ports and register writes
// vertex: two 40-step serial divides between transfer and result
// tick: three 14-step cordic passes when spin is enabled, no result
// throughput: one item at a time, set by the serial divider and cordic unit
// a result waits in an output register; next item is taken meanwhile
// reset (rst_n low, synchronous): registers to defaults, angles zero
module tumbling_vertex_projector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // vert_x, vert_y, vert_z
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // screen_x, screen_y
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  // configuration registers
  logic [11:0] spin_speed_r;
  logic [15:0] shape_scale_r;
  logic [9:0]  canvas_center_r;
  logic        spin_enabled_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spin_speed_r <= tvp_pkg::SPIN_SPEED_RST;
      shape_scale_r <= tvp_pkg::SHAPE_SCALE_RST;
      canvas_center_r <= tvp_pkg::CANVAS_CENTER_RST;
      spin_enabled_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        2'(tvp_pkg::REG_SPIN_SPEED):    spin_speed_r <= cfg_wdata[11:0];
        2'(tvp_pkg::REG_SHAPE_SCALE):   shape_scale_r <= cfg_wdata;
        2'(tvp_pkg::REG_CANVAS_CENTER): canvas_center_r <= cfg_wdata[9:0];
        default:                        spin_enabled_r <= cfg_wdata[0];
      endcase
    end
  end

  tvp_pkg::tvp_cmd_t cmd;
  tvp_pkg::tvp_sts_t sts;
  logic in_fire, out_push, ctrl_ready;
  logic out_valid_r;
  logic [31:0] dp_out, out_data_r;

  assign in_fire = in_tvalid && in_tready;
  assign in_tready = ctrl_ready;

  tvp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_kind(in_tuser),
    .spin_enabled(spin_enabled_r), .out_busy(out_valid_r && !out_tready),
    .sts(sts), .cmd(cmd), .in_ready(ctrl_ready), .out_push(out_push)
  );

  tvp_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .vert_in(in_tdata),
    .spin_speed(spin_speed_r), .shape_scale(shape_scale_r),
    .canvas_center(canvas_center_r), .out_data(dp_out)
  );

  // output holding register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_push) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
    if (out_push) out_data_r <= dp_out;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  // a pushed result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> (!out_valid_r || out_tready))
    else $error("result overwritten");

  // no new input taken while a push is pending
  a_no_accept_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !in_tready)
    else $error("accept during push");

  // divider and cordic never report done together
  a_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.cordic_done && sts.div_done))
    else $error("units done together");

endmodule
